[hw/rtl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int VALUE_BITS = 32;
   localparam int CAND_BITS  = 32;
   // significant candidate bits
   localparam int NBITS      = (VALUE_BITS < CAND_BITS) ? VALUE_BITS : CAND_BITS;
   // divisor never exceeds sqrt(2^NBITS) plus one stride
   localparam int DBITS      = NBITS / 2 + 2;
   localparam int CNT_BITS   = $clog2(NBITS + 1);
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NBITS-1:0] dividend;
      logic [DBITS-1:0] divisor;
   } div_request_type;

   typedef struct packed {
      logic             done;
      logic [NBITS-1:0] quotient;
      logic [DBITS-1:0] remainder;
   } div_result_type;

endpackage

[hw/rtl/tdpt_sdiv.sv]
// ----------------------------------------------------------------------------
// tdpt_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, done pulses
// once when the last bit is in, with quotient and remainder held.
// ----------------------------------------------------------------------------
module tdpt_sdiv
   import tdpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  div_request_type div_req,
   output div_result_type  div_rsp
);

   logic [NBITS-1:0]    work_ff, work_in;
   logic [DBITS-1:0]    rem_ff, rem_in;
   logic [DBITS-1:0]    divisor_ff, divisor_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [DBITS:0]      rem_shift;
   logic [DBITS+1:0]    diff;
   logic                fits;

   always_comb begin
      rem_shift = {rem_ff, work_ff[NBITS-1]};
      diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
      fits      = ~diff[DBITS+1];

      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = CNT_BITS'(NBITS);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[NBITS-2:0], fits};
         rem_in  = fits ? diff[DBITS-1:0] : rem_shift[DBITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[hw/rtl/trial_division_prime_test_core.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Trial division primality test of one unsigned candidate per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. busy stays high
//   while trial divisions run. The result (is_prime, trial_count) appears on
//   the rsp_ ports for exactly one cycle with rsp_valid high; the receiver
//   cannot stall it, so it must sample that cycle.
//   Each trial is one pass of the bit-serial divider, giving quotient and
//   remainder together. Candidates 0 and 1, and even values rejected early
//   when skip_evens is set, are answered without a division; otherwise
//   trial_count gives the number of divisions, plus one more when the
//   square bound ends the search. Worst case for a 32-bit prime is about
//   65535 divisions in plain mode and about 32768 with skip_evens set.
//   One request is in flight at a time.
//   csr_we writes skip_evens from csr_wdata; write only while idle.
//   Reset sets skip_evens to 1, drops busy and clears rsp_valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core
   import tdpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CAND_BITS-1:0]  req_candidate,
   output logic                  rsp_valid,
   output logic                  rsp_is_prime,
   output logic [COUNT_BITS-1:0] rsp_trial_count,
   input  logic                  csr_we,
   input  logic                  csr_wdata
);

   state_type             state_ff, state_in;
   logic                  skip_ff, skip_in;
   logic [NBITS-1:0]      n_ff, n_in;
   logic [DBITS-1:0]      d_ff, d_in;
   logic [COUNT_BITS-1:0] trials_ff, trials_in;
   logic                  valid_ff, valid_in;
   logic                  prime_ff, prime_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   div_request_type div_req;
   div_result_type  div_rsp;

   logic [NBITS-1:0]      cand;
   logic [NBITS-1:0]      d_wide;
   logic [COUNT_BITS-1:0] trials_inc;

   tdpt_sdiv u_sdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      cand       = req_candidate[NBITS-1:0];
      d_wide     = {{(NBITS-DBITS){1'b0}}, d_ff};
      trials_inc = (trials_ff == COUNT_MAX) ? trials_ff : trials_ff + 1'b1;

      state_in  = state_ff;
      skip_in   = csr_we ? csr_wdata : skip_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      trials_in = trials_ff;
      valid_in  = 1'b0;
      prime_in  = prime_ff;
      count_in  = count_ff;

      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = d_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in      = cand;
               trials_in = '0;
               if (cand[NBITS-1:1] == '0 ||
                   (skip_ff && !cand[0] && cand[NBITS-1:2] != '0)) begin
                  valid_in = 1'b1;
                  prime_in = 1'b0;
                  count_in = '0;
               end else begin
                  d_in             = skip_ff ? DBITS'(3) : DBITS'(2);
                  div_req.start    = 1'b1;
                  div_req.dividend = cand;
                  div_req.divisor  = d_in;
                  state_in         = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (d_wide > div_rsp.quotient) begin
                  valid_in = 1'b1;
                  prime_in = 1'b1;
                  count_in = trials_ff;
                  state_in = ST_IDLE;
               end else if (div_rsp.remainder == '0) begin
                  valid_in = 1'b1;
                  prime_in = 1'b0;
                  count_in = trials_inc;
                  state_in = ST_IDLE;
               end else begin
                  trials_in       = trials_inc;
                  d_in            = d_ff + (skip_ff ? DBITS'(2) : DBITS'(1));
                  div_req.start   = 1'b1;
                  div_req.divisor = d_in;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         skip_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
         valid_ff <= valid_in;
      end
      n_ff      <= n_in;
      d_ff      <= d_in;
      trials_ff <= trials_in;
      prime_ff  <= prime_in;
      count_ff  <= count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_is_prime    = prime_ff;
   assign rsp_trial_count = count_ff;

endmodule

[hw/rtl/tdpt_checker.sv]
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level temporal checks for the trial division prime test core.
// ----------------------------------------------------------------------------
module tdpt_checker
   import tdpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_is_prime,
   input logic [COUNT_BITS-1:0] rsp_trial_count
);

   // a taken request either finishes at once or keeps the core busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request taken without progress");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("activity right after reset");

   // a composite found by trials always comes out of a search
   a_prime_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_prime && rsp_trial_count != '0) |-> $past(busy))
      else $error("composite with trials reported without a search");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_is_prime    (rsp_is_prime),
   .rsp_trial_count (rsp_trial_count)
);
